FILE: rtl/core/hcbp_pkg.sv
`default_nettype none

package hcbp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int IDX_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    // Loaded lengths saturate at the smaller of the two limits.
    localparam int LEN_CAP_INT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FINAL = 2'd1,
        KIND_COUNT = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } code_entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/hcbp_ifs.sv
`default_nettype none

interface hcbp_req_if;
    import hcbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;

    modport source (output valid, output req_type, output symbol, output code_bits,
                    output code_len, input ready);
    modport sink   (input valid, input req_type, input symbol, input code_bits,
                    input code_len, output ready);
endinterface

interface hcbp_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/huffman_code_bit_packer_core.sv
`default_nettype none

// Huffman code packer. A load beat writes one code table entry (symbol, right-aligned
// code, length; lengths above 32 saturate). An encode beat looks up the symbol,
// left-aligns its code with one shift, then a single bit inserter moves up to eight
// code bits per cycle, while the buffer is not full, into the byte buffer, and each full
// byte leaves through the output register in a cycle of its own once the next code bit
// is pending. A flush sends the zero-padded final byte and then its bit count (1 to 8).
// An unknown symbol, or one loaded with length zero, gives one error beat carrying the
// symbol. The block takes no new request while an encode or flush is in progress; the
// last beat of each request has last set.
module huffman_code_bit_packer_core (
    input  wire        clk,
    input  wire        rst_n,
    hcbp_req_if.sink   req,
    hcbp_res_if.source res
);
    import hcbp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_CHECK    = 5'b00010,
        S_PACK     = 5'b00100,
        S_FL_FINAL = 5'b01000,
        S_FL_COUNT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    code_entry_t code_mem [SYMBOL_COUNT];
    code_entry_t rd_entry_reg;
    logic [SYMBOL_COUNT-1:0] code_vld_reg, code_vld_next;

    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic              sym_ok_reg, sym_ok_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [7:0]        buf_reg, buf_next;
    logic [3:0]        bits_held_reg, bits_held_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic [1:0] out_kind_reg, out_kind_next;
    logic       out_last_reg, out_last_next;

    logic accept;
    logic slot_free;
    logic sym_in_range;
    logic [LEN_W-1:0] len_sat;
    logic mem_wr;
    logic mem_rd;
    logic entry_ok;
    logic [3:0] room;
    logic [3:0] take;

    assign req.ready    = (state_reg == S_IDLE);
    assign accept       = req.valid && req.ready;
    assign slot_free    = !out_valid_reg || res.ready;
    assign sym_in_range = ({1'b0, req.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign len_sat      = (req.code_len > LEN_CAP) ? LEN_CAP : req.code_len;
    assign mem_wr       = accept && (req.req_type == REQ_LOAD) && sym_in_range;
    assign mem_rd       = accept && (req.req_type == REQ_ENCODE);

    assign entry_ok = sym_ok_reg && code_vld_reg[sym_reg[IDX_W-1:0]]
                      && (rd_entry_reg.len != '0);

    // Bits taken this step: the free room in the buffer or what is left of the code.
    assign room = 4'd8 - bits_held_reg;
    assign take = (rem_reg < {2'b00, room}) ? rem_reg[3:0] : room;

    assign res.valid    = out_valid_reg;
    assign res.out_byte = out_byte_reg;
    assign res.kind     = out_kind_reg;
    assign res.last     = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            code_mem[req.symbol[IDX_W-1:0]] <= '{len: len_sat, code: req.code_bits};
        end
        if (mem_rd)
        begin
            rd_entry_reg <= code_mem[req.symbol[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        code_vld_next  = code_vld_reg;
        sym_next       = sym_reg;
        sym_ok_next    = sym_ok_reg;
        code_next      = code_reg;
        rem_next       = rem_reg;
        buf_next       = buf_reg;
        bits_held_next = bits_held_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_LOAD:
                        begin
                            if (sym_in_range)
                            begin
                                code_vld_next[req.symbol[IDX_W-1:0]] = 1'b1;
                            end
                        end
                        REQ_ENCODE:
                        begin
                            sym_next    = req.symbol;
                            sym_ok_next = sym_in_range;
                            state_next  = S_CHECK;
                        end
                        REQ_FLUSH:
                        begin
                            if (bits_held_reg != 4'd0)
                            begin
                                state_next = S_FL_FINAL;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (entry_ok)
                begin
                    code_next  = rd_entry_reg.code << (LEN_W'(CODE_W) - rd_entry_reg.len);
                    rem_next   = rd_entry_reg.len;
                    state_next = S_PACK;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = sym_reg;
                    out_kind_next  = KIND_ERROR;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_PACK:
            begin
                if (bits_held_reg == 4'd8)
                begin
                    // A full byte leaves only because more code bits are pending.
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = buf_reg;
                        out_kind_next  = KIND_DATA;
                        out_last_next  = (rem_reg <= LEN_W'(8));
                        buf_next       = 8'd0;
                        bits_held_next = 4'd0;
                    end
                end
                else
                begin
                    buf_next       = buf_reg | (code_reg[CODE_W-1 -: 8] >> bits_held_reg);
                    code_next      = code_reg << take;
                    rem_next       = rem_reg - {2'b00, take};
                    bits_held_next = bits_held_reg + take;
                    if (rem_reg == {2'b00, take})
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FL_FINAL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = buf_reg;
                    out_kind_next  = KIND_FINAL;
                    out_last_next  = 1'b0;
                    state_next     = S_FL_COUNT;
                end
            end
            S_FL_COUNT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = {4'd0, bits_held_reg};
                    out_kind_next  = KIND_COUNT;
                    out_last_next  = 1'b1;
                    buf_next       = 8'd0;
                    bits_held_next = 4'd0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            code_vld_reg  <= '0;
            buf_reg       <= 8'd0;
            bits_held_reg <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_vld_reg  <= code_vld_next;
            buf_reg       <= buf_next;
            bits_held_reg <= bits_held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        sym_ok_reg   <= sym_ok_next;
        code_reg     <= code_next;
        rem_reg      <= rem_next;
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    a_bits_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_held_reg <= 4'd8)
        else $error("byte buffer holds more than eight bits");

    a_pack_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PACK) |-> (rem_reg != '0))
        else $error("packing with no code bits left");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FL_COUNT && slot_free) |=> (bits_held_reg == 4'd0))
        else $error("flush left bits in the buffer");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_ERROR) |-> out_last_reg)
        else $error("error beat without last");

    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FL_FINAL) |-> (bits_held_reg != 4'd0))
        else $error("flush started with an empty buffer");

endmodule

`default_nettype wire

FILE: tb/hcbp_code_checker.sv
`timescale 1ns / 1ps

module hcbp_code_checker
    import hcbp_pkg::*;
(
    input  wire clk,
    input  wire rst_n,
    hcbp_req_if req,
    hcbp_res_if res,
    output int  mismatches,
    output int  outstanding
);

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last;
    } packed_byte_t;

    code_entry_t  code_table [SYMBOL_COUNT];
    logic [7:0]   pack_buf;
    logic [3:0]   pack_fill;
    packed_byte_t byte_q [$];

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Works out the beats that one request beat causes and queues them in order.
    task automatic predict_request(input logic [1:0] rtype, input logic [7:0] sym,
                                   input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
        code_entry_t  entry;
        logic [LEN_W-1:0] clen;
        packed_byte_t emitted [$];
        case (req_type_t'(rtype))
            REQ_LOAD:
            begin
                clen = (len > LEN_CAP) ? LEN_CAP : len;
                if (int'(sym) < SYMBOL_COUNT)
                    code_table[sym] = {clen, bits};
            end
            REQ_ENCODE:
            begin
                if (int'(sym) >= SYMBOL_COUNT || code_table[sym].len == '0)
                begin
                    emitted.push_back('{out_byte: sym, kind: KIND_ERROR, last: 1'b1});
                end
                else
                begin
                    entry = code_table[sym];
                    for (int i = int'(entry.len); i > 0; i--)
                    begin
                        // A full byte only leaves once another code bit shows up.
                        if (pack_fill == 4'd8)
                        begin
                            emitted.push_back('{out_byte: pack_buf, kind: KIND_DATA,
                                                last: 1'b0});
                            pack_buf  = '0;
                            pack_fill = '0;
                        end
                        pack_buf[7 - pack_fill] = entry.code[i - 1];
                        pack_fill++;
                    end
                    if (emitted.size() > 0)
                        emitted[emitted.size() - 1].last = 1'b1;
                end
            end
            REQ_FLUSH:
            begin
                if (pack_fill != '0)
                begin
                    emitted.push_back('{out_byte: pack_buf, kind: KIND_FINAL, last: 1'b0});
                    emitted.push_back('{out_byte: 8'(pack_fill), kind: KIND_COUNT,
                                        last: 1'b1});
                    pack_buf  = '0;
                    pack_fill = '0;
                end
            end
            default:
            begin
            end
        endcase
        foreach (emitted[k])
            byte_q.push_back(emitted[k]);
    endtask

    task automatic check_result();
        packed_byte_t want;
        if (byte_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected beat byte=%02h kind=%0d last=%0b",
                                      res.out_byte, res.kind, res.last));
        end
        else
        begin
            want = byte_q.pop_front();
            if (res.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, expected %02h",
                                          res.out_byte, want.out_byte));
            if (res.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", res.kind, want.kind));
            if (res.last !== want.last)
                report_mismatch($sformatf("last %0b, expected %0b", res.last, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (code_table[s])
                code_table[s] = '0;
            pack_buf    = '0;
            pack_fill   = '0;
            byte_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                predict_request(req.req_type, req.symbol, req.code_bits, req.code_len);
            if (res.valid && res.ready)
                check_result();
            outstanding = byte_q.size();
        end
    end

endmodule

FILE: tb/huffman_code_bit_packer_core_tb.sv
`timescale 1ns / 1ps

module huffman_code_bit_packer_core_tb;
    import hcbp_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 75;
    localparam int SETTLE_TICKS = 50;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_pending;
    logic [7:0] sym_pool [16];

    hcbp_req_if req_if ();
    hcbp_res_if res_if ();

    huffman_code_bit_packer_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if)
    );

    hcbp_code_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .res         (res_if),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("huffman_code_bit_packer_core_tb NOT OK");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input req_type_t rtype, input logic [7:0] sym,
                             input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= rtype;
        req_if.symbol    <= sym;
        req_if.code_bits <= bits;
        req_if.code_len  <= len;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return LEN_W'($urandom_range(10, 1));
        else if (roll < 88)
            return LEN_W'($urandom_range(32, 11));
        else if (roll < 95)
            return LEN_W'($urandom_range(63, 33));
        return '0;
    endfunction

    function automatic logic [7:0] pick_symbol();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        return sym_pool[$urandom_range(15)];
    endfunction

    // Mostly encodes of loaded symbols; loads, flushes and unused requests mixed in.
    // Returns 1 when the item was one the block acts on.
    task automatic random_request(output bit counted);
        int roll;
        roll    = $urandom_range(99);
        counted = 1'b1;
        if (roll < 14)
            send_item(REQ_LOAD, pick_symbol(), $urandom, pick_length());
        else if (roll < 82)
            send_item(REQ_ENCODE, pick_symbol(), $urandom, LEN_W'($urandom_range(63)));
        else if (roll < 94)
            send_item(REQ_FLUSH, 8'($urandom_range(255)), $urandom,
                      LEN_W'($urandom_range(63)));
        else
        begin
            send_item(REQ_NONE, 8'($urandom_range(255)), $urandom,
                      LEN_W'($urandom_range(63)));
            counted = 1'b0;
        end
    endtask

    initial
    begin
        bit counted;
        int done;
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_NONE;
        req_if.symbol    = '0;
        req_if.code_bits = '0;
        req_if.code_len  = '0;
        hold_pending     = 1'b0;
        send_idle_pct    = 20;
        recv_idle_pct    = 56;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unknown symbols, empty flush and an unused request on a fresh table.
        send_item(REQ_ENCODE, 8'h00, 32'h0, 6'd0);
        send_item(REQ_ENCODE, 8'hFF, 32'hFFFF_FFFF, 6'd63);
        send_item(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
        send_item(REQ_NONE, 8'hFF, 32'hFFFF_FFFF, 6'd63);
        // Full-width codes, lengths that saturate, and a code removed by a zero length.
        send_item(REQ_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
        send_item(REQ_LOAD, 8'hFF, 32'h0000_0000, 6'd1);
        send_item(REQ_LOAD, 8'h5A, 32'hA5A5_5A5A, 6'd63);
        send_item(REQ_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd33);
        send_item(REQ_LOAD, 8'h03, 32'hFFFF_FFFE, 6'd3);
        send_item(REQ_LOAD, 8'h02, 32'h0000_1234, 6'd5);
        send_item(REQ_LOAD, 8'h02, 32'hFFFF_FFFF, 6'd0);
        send_item(REQ_ENCODE, 8'h02, 32'h0, 6'd0);
        send_item(REQ_ENCODE, 8'h00, 32'h0, 6'd0);
        send_item(REQ_ENCODE, 8'hFF, 32'h0, 6'd0);
        send_item(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
        send_item(REQ_ENCODE, 8'h5A, 32'h0, 6'd0);
        send_item(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
        send_item(REQ_ENCODE, 8'h03, 32'h0, 6'd0);
        send_item(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
        // A full byte held when a long code arrives.
        send_item(REQ_ENCODE, 8'h01, 32'h0, 6'd0);
        send_item(REQ_ENCODE, 8'h5A, 32'h0, 6'd0);
        send_item(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
        send_item(REQ_FLUSH, 8'h00, 32'h0, 6'd0);

        foreach (sym_pool[p])
        begin
            sym_pool[p] = 8'($urandom_range(255));
            send_item(REQ_LOAD, sym_pool[p], $urandom, pick_length());
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 20;
                    recv_idle_pct = 56;
                end
                1:
                begin
                    send_idle_pct = 56;
                    recv_idle_pct = 20;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // The result side stops for a long while; requests keep coming.
                    hold_pending = 1'b1;
                end
            endcase
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                random_request(counted);
                if (counted)
                    done++;
            end
        end
        send_item(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
        req_if.valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatches == 0)
            $display("huffman_code_bit_packer_core_tb OK");
        else
            $display("huffman_code_bit_packer_core_tb NOT OK");
        $finish;
    end

endmodule
